[rtl/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form: clk_i and rst_ni of the enclosing module.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/acba_pkg.sv]
`timescale 1ns / 1ps

package acba_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 4;
  localparam int QSLOT_W  = 2;
  localparam int AVG_W    = 12;
  localparam int BSUM_W   = 22;
  localparam int BCNT_W   = 11;
  localparam int GSUM_W   = 48;
  localparam int GCNT_W   = 32;
  localparam int MAP_W    = 40;
  localparam int LEN_W    = 11;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 96;

  localparam logic [MAP_W-1:0] MAP_RESET = '1;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd32;
  localparam logic [LEN_W-1:0] LEN_MAX   = 11'd1024;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LENGTH = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic KIND_AVERAGE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

endpackage

[rtl/adc_channel_batch_averager_top.sv]
`timescale 1ns / 1ps
// ADC channel batch averager.
// Slave stream: one word per conversion or read request; tuser is the op.
// Master stream: batch-average and read-reply words; tuser is the kind.
// Config channel: cfg_index_i 0 writes the channel map, 1 the batch length;
// always ready, write only while the block is idle.
// Timing: a word is taken only in the idle state. A sample that closes no
// batch goes through the process state back to idle; a read request goes
// through process to emit, where the reply is loaded into the output
// register, then back to idle for the next word; a sample that closes a
// batch runs the bit-serial restoring divider (one quotient bit per cycle)
// before emit. No new word is taken before the block is back in idle.
// The output register frees the input side: a new word is accepted while a
// result waits. If the receiver stalls and a second result is ready, the
// block holds that result internally and takes no word until the register
// drains.
// Reset clears all slot state, sets the map to all-ignore and the batch
// length to 32.
module adc_channel_batch_averager_top
  import acba_pkg::*;
#(
  parameter int NUM_SLOTS       = 4,
  parameter int NUM_HW_CHANNELS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // adc_channel[3:0], sample_value[15:4], query_slot[17:16], zero pad
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  // op
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slot[1:0], average[13:2], total_sum[61:14], total_count[93:62], zero pad
  output logic [M_TDATA_W-1:0]   m_axis_tdata,
  // kind
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [MAP_W-1:0]       cfg_data_i
);

  `include "assert_macros.svh"

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DVD_W  = BSUM_W;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DVD_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  logic [MAP_W-1:0] map_q;
  logic [LEN_W-1:0] len_q;

  logic [BSUM_W-1:0] bsum_q [NUM_SLOTS];
  logic [BCNT_W-1:0] bcnt_q [NUM_SLOTS];
  logic [GSUM_W-1:0] gsum_q [NUM_SLOTS];
  logic [GCNT_W-1:0] gcnt_q [NUM_SLOTS];
  logic [AVG_W-1:0]  lavg_q [NUM_SLOTS];

  logic                op_q;
  logic [CHAN_W-1:0]   ch_q;
  logic [SAMPLE_W-1:0] val_q;
  logic [QSLOT_W-1:0]  qs_q;

  logic              res_kind_q;
  logic [1:0]        res_slot_q;
  logic [AVG_W-1:0]  res_avg_q;
  logic [GSUM_W-1:0] res_sum_q;
  logic [GCNT_W-1:0] res_cnt_q;
  logic [SLOT_W-1:0] slot_q;

  logic [DVD_W-1:0]  dq_q, dq_d;
  logic [BCNT_W-1:0] rem_q, rem_d;
  logic [BCNT_W-1:0] dvs_q;
  logic [DCNT_W-1:0] dcnt_q;

  logic              out_valid_q;
  logic              out_kind_q;
  logic [1:0]        out_slot_q;
  logic [AVG_W-1:0]  out_avg_q;
  logic [GSUM_W-1:0] out_sum_q;
  logic [GCNT_W-1:0] out_cnt_q;

  logic              s_fire, emit_fire;
  logic              ch_ok, hit, done, q_ok;
  logic [3:0]        ent, q_ext;
  logic [SLOT_W-1:0] sidx, qidx;
  logic [BSUM_W-1:0] bsum_new;
  logic [BCNT_W-1:0] bcnt_new;
  logic [LEN_W-1:0]  eff_len;
  logic [BCNT_W:0]   trial, trial_sub;
  logic              ge;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign emit_fire     = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign ch_ok    = ch_q < CHAN_W'(NUM_HW_CHANNELS);
  assign ent      = ch_ok ? map_q[{ch_q, 2'b00} +: 4] : 4'hF;
  assign hit      = ch_ok && (ent < 4'(NUM_SLOTS));
  assign sidx     = ent[SLOT_W-1:0];
  assign q_ext    = {2'b00, qs_q};
  assign q_ok     = q_ext < 4'(NUM_SLOTS);
  assign qidx     = q_ext[SLOT_W-1:0];
  assign bsum_new = bsum_q[sidx] + BSUM_W'(val_q);
  assign bcnt_new = bcnt_q[sidx] + BCNT_W'(1);

  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_q > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = len_q;
    end
  end

  assign done = (bcnt_new != '0) && (bcnt_new >= eff_len);

  // restoring division step
  assign trial     = {rem_q, dq_q[DVD_W-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign rem_d     = ge ? trial_sub[BCNT_W-1:0] : trial[BCNT_W-1:0];
  assign dq_d      = {dq_q[DVD_W-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        if (op_q == OP_READ) begin
          state_d = ST_EMIT;
        end else if (hit && done) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (dcnt_q == DIV_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      map_q       <= MAP_RESET;
      len_q       <= LEN_RESET;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bsum_q[i] <= '0;
        bcnt_q[i] <= '0;
        gsum_q[i] <= '0;
        gcnt_q[i] <= '0;
        lavg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CHANNEL_MAP:  map_q <= cfg_data_i;
          CFG_BATCH_LENGTH: len_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_PROC && op_q == OP_SAMPLE && hit) begin
        gsum_q[sidx] <= gsum_q[sidx] + GSUM_W'(val_q);
        gcnt_q[sidx] <= gcnt_q[sidx] + GCNT_W'(1);
        bsum_q[sidx] <= done ? '0 : bsum_new;
        bcnt_q[sidx] <= done ? '0 : bcnt_new;
      end
      if (state_q == ST_PROC) begin
        dcnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
        if (dcnt_q == DIV_LAST) begin
          lavg_q[slot_q] <= dq_d[AVG_W-1:0];
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q  <= s_axis_tuser;
      ch_q  <= s_axis_tdata[3:0];
      val_q <= s_axis_tdata[15:4];
      qs_q  <= s_axis_tdata[17:16];
    end
    if (state_q == ST_PROC) begin
      if (op_q == OP_READ) begin
        res_kind_q <= KIND_READ;
        res_slot_q <= qs_q;
        res_avg_q  <= q_ok ? lavg_q[qidx] : '0;
        res_sum_q  <= q_ok ? gsum_q[qidx] : '0;
        res_cnt_q  <= q_ok ? gcnt_q[qidx] : '0;
      end else begin
        res_kind_q <= KIND_AVERAGE;
        res_slot_q <= ent[1:0];
        res_avg_q  <= '0;
        res_sum_q  <= gsum_q[sidx] + GSUM_W'(val_q);
        res_cnt_q  <= gcnt_q[sidx] + GCNT_W'(1);
      end
      slot_q <= sidx;
      dq_q   <= bsum_new + BSUM_W'(bcnt_new >> 1);
      rem_q  <= '0;
      dvs_q  <= bcnt_new;
    end else if (state_q == ST_DIV) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
    if (emit_fire) begin
      out_kind_q <= res_kind_q;
      out_slot_q <= res_slot_q;
      out_avg_q  <= (res_kind_q == KIND_READ) ? res_avg_q : dq_q[AVG_W-1:0];
      out_sum_q  <= res_sum_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q, out_sum_q, out_avg_q, out_slot_q};

  `ASSERT_DEF(a_one_word_at_a_time, s_fire |=> !s_axis_tready, "word taken while busy")
  `ASSERT_DEF(a_div_count_range, (state_q == ST_DIV) |-> (dcnt_q <= DIV_LAST), "divider overrun")
  `ASSERT_DEF(a_quotient_fits,
    (state_q == ST_DIV && dcnt_q == DIV_LAST) |=> (dq_q[DVD_W-1:AVG_W] == '0),
    "average exceeds 12 bits")
  `ASSERT_DEF(a_batch_bound, bcnt_q[0] <= LEN_MAX, "batch count beyond limit")
  `ASSERT_DEF(a_emit_loads_output, emit_fire |=> m_axis_tvalid, "result lost")

endmodule
